// ===== rtl/gds_pkg.sv =====
package gds_pkg;

   localparam logic [13:0] MAX_YEAR = 14'd9999;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   // y * RECIP_100 >> RECIP_SHIFT == y / 100 for every 14-bit y
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   typedef struct packed {
      logic [4:0]  in_day;
      logic [3:0]  in_month;
      logic [13:0] in_year;
   } req_type;

   typedef struct packed {
      logic        date_valid;
      logic        leap_year;
      logic [4:0]  following_day;
      logic [3:0]  following_month;
      logic [13:0] following_year;
      logic [4:0]  preceding_day;
      logic [3:0]  preceding_month;
      logic [13:0] preceding_year;
      logic [21:0] serial_day;
      logic [5:0]  weeks_before_month;
   } rsp_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // days before the first of the month in a common year
   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] days;
      case (m)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   // ceil(days before month / 7); the leap day only changes October
   function automatic logic [5:0] weeks_before(input logic [3:0] m, input logic leap);
      logic [5:0] weeks;
      case (m)
         4'd1:    weeks = 6'd0;
         4'd2:    weeks = 6'd5;
         4'd3:    weeks = 6'd9;
         4'd4:    weeks = 6'd13;
         4'd5:    weeks = 6'd18;
         4'd6:    weeks = 6'd22;
         4'd7:    weeks = 6'd26;
         4'd8:    weeks = 6'd31;
         4'd9:    weeks = 6'd35;
         4'd10:   weeks = leap ? 6'd40 : 6'd39;
         4'd11:   weeks = 6'd44;
         4'd12:   weeks = 6'd48;
         default: weeks = 6'd0;
      endcase
      return weeks;
   endfunction

endpackage

// ===== rtl/gds_calc.sv =====
module gds_calc
   import gds_pkg::*;
(
   input  req_type date_in,
   output rsp_type result
);

   logic [4:0]  d;
   logic [3:0]  m;
   logic [13:0] y;
   logic [26:0] prod;
   logic [7:0]  q100;
   logic        r100_zero;
   logic        leap;
   logic [4:0]  mlen;
   logic        valid;
   logic [13:0] yp;
   logic [7:0]  q100p;
   logic [9:0]  days_prior;
   logic [3:0]  pm;

   assign d = date_in.in_day;
   assign m = date_in.in_month;
   assign y = date_in.in_year;

   // One reciprocal multiply gives y / 100; the low bits stay below the
   // constant exactly when y is a multiple of 100.
   assign prod      = 27'(y) * 27'(RECIP_100);
   assign q100      = prod[26:RECIP_SHIFT];
   assign r100_zero = (prod[RECIP_SHIFT-1:0] < 19'(RECIP_100));

   assign leap = ((y[1:0] == 2'd0) && !r100_zero) || (r100_zero && (q100[1:0] == 2'd0));
   assign mlen = month_len(m, leap);

   assign valid = (m >= MONTH_JAN) && (m <= MONTH_DEC) && (y != 14'd0) &&
                  (y <= MAX_YEAR) && (d != 5'd0) && (d <= mlen);

   // quotients of y - 1 follow from those of y
   assign yp    = y - 14'd1;
   assign q100p = q100 - {7'd0, r100_zero};

   assign days_prior = {1'b0, days_before(m)} + {9'd0, (leap && (m > MONTH_FEB))};
   assign pm         = (m == MONTH_JAN) ? MONTH_DEC : (m - 4'd1);

   always_comb begin
      result = '0;
      result.leap_year  = leap;
      result.date_valid = valid;
      if (valid) begin
         if (d == mlen) begin
            result.following_day = 5'd1;
            if (m == MONTH_DEC) begin
               result.following_month = MONTH_JAN;
               result.following_year  = y + 14'd1;
            end else begin
               result.following_month = m + 4'd1;
               result.following_year  = y;
            end
         end else begin
            result.following_day   = d + 5'd1;
            result.following_month = m;
            result.following_year  = y;
         end

         if (d == 5'd1) begin
            result.preceding_day   = month_len(pm, leap);
            result.preceding_month = pm;
            result.preceding_year  = (m == MONTH_JAN) ? yp : y;
         end else begin
            result.preceding_day   = d - 5'd1;
            result.preceding_month = m;
            result.preceding_year  = y;
         end

         result.serial_day = 22'(yp) * 22'd365 + 22'(yp[13:2]) - 22'(q100p) +
                             22'(q100p[7:2]) + 22'(days_prior) + 22'(d);
         result.weeks_before_month = weeks_before(m, leap);
      end
   end

endmodule

// ===== rtl/gregorian_date_step_and_day_number_core.sv =====
// Path: accepted request beat -> input register -> date math -> result register,
//    whose output is rsp_valid; the two registers form a ready/valid pipeline.
// Throughput: one date per cycle while rsp_ready does not stall the output.
// Reset: synchronous, active high; clears both stage valid flags, payload is not reset.
module gregorian_date_step_and_day_number_core
   import gds_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // stage 1: captured request
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   // stage 2: finished result waiting for the consumer
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   rsp_type calc_result;
   logic    out_take;   // result register can load this cycle
   logic    s1_take;    // input register can load this cycle

   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign s1_take   = !s1_valid_ff || out_take;
   assign req_ready = s1_take;

   // all the calendar math sits between the two registers
   gds_calc u_calc (
      .date_in (s1_data_ff),
      .result  (calc_result)
   );

   always_comb begin
      s1_valid_in  = s1_take ? req_valid : s1_valid_ff;
      rsp_valid_in = out_take ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: new request beat only when stage 1 frees up; result holds while stalled
   always_ff @(posedge clock) begin
      if (s1_take && req_valid) begin
         s1_data_ff <= req_data;
      end
      if (out_take && s1_valid_ff) begin
         rsp_data_ff <= calc_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/gds_checker.sv =====
module gds_checker
   import gds_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // no result beat right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // invalid date gives zero dates and counts
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.date_valid |->
         rsp_data.following_day == 5'd0 && rsp_data.preceding_day == 5'd0 &&
         rsp_data.serial_day == 22'd0 && rsp_data.weeks_before_month == 6'd0)
      else $error("invalid date with nonzero result fields");

   // valid date gives dates in range
   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.date_valid |->
         rsp_data.following_day != 5'd0 && rsp_data.preceding_day != 5'd0 &&
         rsp_data.following_month >= MONTH_JAN && rsp_data.following_month <= MONTH_DEC &&
         rsp_data.preceding_month >= MONTH_JAN && rsp_data.preceding_month <= MONTH_DEC &&
         rsp_data.serial_day != 22'd0)
      else $error("valid date with out-of-range result");

endmodule

bind gregorian_date_step_and_day_number_core gds_checker u_gds_checker (.*);
